FILE: design/rcbs_pkg.sv
// ---------------------------------------------------------------------------
// rcbs_pkg: shared types, constants and tables
// Fixed-point format, register codes and the constant lookup tables used by
// the brightness, contrast and saturation pixel adjuster.
// ---------------------------------------------------------------------------
package rcbs_pkg;

  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned FX_W      = FRAC_BITS + 1;
  localparam int unsigned PROD_W    = 2 * FX_W;
  localparam int unsigned CHAN_W    = 8;
  localparam int unsigned PCT_W     = 7;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned NUM_CHAN  = 3;
  localparam int unsigned NUM_STAGE = 8;

  localparam longint unsigned PctMax  = 100;
  localparam longint unsigned ChanMax = (64'd1 << CHAN_W) - 1;
  localparam longint unsigned FxOne   = 64'd1 << FRAC_BITS;

  typedef logic [CHAN_W-1:0]    chan_t;
  typedef logic [PCT_W-1:0]     pct_t;
  typedef logic [FX_W-1:0]      fx_t;
  typedef logic [PROD_W-1:0]    prod_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam fx_t FX_ONE = fx_t'(FxOne);
  localparam fx_t KR     = fx_t'((37 * FxOne + 50) / PctMax);
  localparam fx_t KG     = fx_t'((24 * FxOne + 50) / PctMax);
  localparam fx_t KB     = fx_t'(FxOne - ((37 * FxOne + 50) / PctMax)
                                 - ((24 * FxOne + 50) / PctMax));

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CONTRAST   = 2'd0,
    REG_BRIGHTNESS = 2'd1,
    REG_SATURATION = 2'd2
  } cfg_reg_t;

  localparam pct_t CONTRAST_RESET   = pct_t'(100);
  localparam pct_t BRIGHTNESS_RESET = pct_t'(50);
  localparam pct_t SATURATION_RESET = pct_t'(100);

  typedef struct packed {
    fx_t s;
    fx_t b;
    fx_t f;
  } cfg_fx_t;

  typedef fx_t pct_tab_t  [2**PCT_W];
  typedef fx_t chan_tab_t [2**CHAN_W];

  // Percent code to fraction of one; codes above 100 read as 100.
  function automatic pct_tab_t build_pct_tab();
    pct_tab_t        tab;
    longint unsigned p;
    for (int i = 0; i < 2**PCT_W; i++) begin
      p = (i > PctMax) ? PctMax : longint'(i);
      tab[i] = fx_t'((p * FxOne) / PctMax);
    end
    return tab;
  endfunction

  // Channel code to fraction of one, rounded up so full scale maps back.
  function automatic chan_tab_t build_chan_tab();
    chan_tab_t tab;
    for (int i = 0; i < 2**CHAN_W; i++) begin
      tab[i] = fx_t'((longint'(i) * FxOne + ChanMax - 1) / ChanMax);
    end
    return tab;
  endfunction

  localparam pct_tab_t  PCT_TAB  = build_pct_tab();
  localparam chan_tab_t CHAN_TAB = build_chan_tab();

endpackage

FILE: design/rcbs_if.sv
// ---------------------------------------------------------------------------
// rcbs_in_if / rcbs_out_if: pixel stream channels
// Valid/ready channels carrying one RGB888 pixel per request.
// ---------------------------------------------------------------------------
interface rcbs_in_if import rcbs_pkg::*; ();
  logic  valid;
  logic  ready;
  chan_t red_in;
  chan_t green_in;
  chan_t blue_in;

  modport source(output valid, red_in, green_in, blue_in, input ready);
  modport sink(input valid, red_in, green_in, blue_in, output ready);
endinterface

interface rcbs_out_if import rcbs_pkg::*; ();
  logic  valid;
  logic  ready;
  chan_t red_out;
  chan_t green_out;
  chan_t blue_out;

  modport source(output valid, red_out, green_out, blue_out, input ready);
  modport sink(input valid, red_out, green_out, blue_out, output ready);
endinterface

FILE: design/rcbs_cfg.sv
// ---------------------------------------------------------------------------
// rcbs_cfg: adjustment register file
// Holds contrast, brightness and saturation, saturated to 100 percent and
// kept directly in fixed-point form for the datapath.
// ---------------------------------------------------------------------------
module rcbs_cfg import rcbs_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     cfg_we,
  input  cfg_idx_t cfg_index,
  input  pct_t     cfg_data,
  output cfg_fx_t  cfg_fx
);

  cfg_fx_t regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.s <= PCT_TAB[CONTRAST_RESET];
      regs.b <= PCT_TAB[BRIGHTNESS_RESET];
      regs.f <= PCT_TAB[SATURATION_RESET];
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CONTRAST:   regs.s <= PCT_TAB[cfg_data];
        REG_BRIGHTNESS: regs.b <= PCT_TAB[cfg_data];
        REG_SATURATION: regs.f <= PCT_TAB[cfg_data];
        default: begin
        end
      endcase
    end
  end

  assign cfg_fx = regs;

endmodule

FILE: design/rgb_contrast_brightness_saturation.sv
// ---------------------------------------------------------------------------
// rgb_contrast_brightness_saturation: RGB888 pixel adjuster
// Applies contrast, brightness and saturation to a stream of pixels.
// ---------------------------------------------------------------------------
// Pixels enter on the pixels channel and leave on the adjusted channel, both
// valid/ready; a request moves one RGB888 pixel. One pixel out follows each
// pixel in, in order.
// The datapath is an eight-stage pipeline: channel scaling, contrast product,
// brightness offset, luminance weights, luminance sum, saturation products,
// blend, and rescale to 8 bits into the output register. An accepted pixel
// moves through the stages in order and is offered on adjusted from the
// output register.
// One pixel is accepted every cycle while the receiver keeps up. Each stage
// holds its pixel while the next stage is full and held, so a stalled receiver
// fills empty stages first; pixels is held off only once all eight are full.
// Configuration writes go through cfg_we, cfg_index and cfg_data: index 0 is
// contrast, 1 brightness, 2 saturation, in percent; values above 100 are
// taken as 100 and index 3 is ignored. Write only while the pipeline is empty.
// Reset empties the pipeline and sets contrast 100, brightness 50 and
// saturation 100.
// ---------------------------------------------------------------------------
module rgb_contrast_brightness_saturation import rcbs_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  rcbs_in_if.sink       pixels,
  rcbs_out_if.source    adjusted,
  input  logic          cfg_we,
  input  cfg_idx_t      cfg_index,
  input  pct_t          cfg_data
);

  cfg_fx_t cfg_fx;

  rcbs_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_fx    (cfg_fx)
  );

  logic [NUM_STAGE:1] vld;
  logic [NUM_STAGE:1] en;

  chan_t px_in [NUM_CHAN];
  fx_t   x1    [NUM_CHAN];
  prod_t off1;
  prod_t p2    [NUM_CHAN];
  prod_t off2;
  fx_t   t3    [NUM_CHAN];
  prod_t w4    [NUM_CHAN];
  fx_t   t4    [NUM_CHAN];
  fx_t   y5;
  fx_t   t5    [NUM_CHAN];
  prod_t gy6;
  prod_t ft6   [NUM_CHAN];
  fx_t   v7    [NUM_CHAN];
  chan_t o8    [NUM_CHAN];

  logic [FX_W+CHAN_W-1:0] scl   [NUM_CHAN];
  logic [CHAN_W:0]        q     [NUM_CHAN];
  chan_t                  o_next[NUM_CHAN];
  prod_t                  ysum;

  assign px_in[0] = pixels.red_in;
  assign px_in[1] = pixels.green_in;
  assign px_in[2] = pixels.blue_in;

  // A stage takes new data when it is empty or its contents move on.
  always_comb begin
    en[NUM_STAGE] = !vld[NUM_STAGE] || adjusted.ready;
    for (int k = NUM_STAGE - 1; k >= 1; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign pixels.ready = en[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[1]) begin
        vld[1] <= pixels.valid;
      end
      for (int k = 2; k <= NUM_STAGE; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  assign ysum = prod_t'(w4[0] + w4[1] + w4[2]);

  always_comb begin
    for (int i = 0; i < NUM_CHAN; i++) begin
      scl[i]    = {v7[i], {CHAN_W{1'b0}}} - {{CHAN_W{1'b0}}, v7[i]};
      q[i]      = scl[i][FX_W+CHAN_W-1:FRAC_BITS];
      o_next[i] = q[i][CHAN_W] ? {CHAN_W{1'b1}} : q[i][CHAN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int i = 0; i < NUM_CHAN; i++) begin
        x1[i] <= CHAN_TAB[px_in[i]];
      end
      off1 <= prod_t'(cfg_fx.b) * prod_t'(FX_ONE - cfg_fx.s);
    end
    if (en[2]) begin
      for (int i = 0; i < NUM_CHAN; i++) begin
        p2[i] <= prod_t'(x1[i]) * prod_t'(cfg_fx.s);
      end
      off2 <= off1;
    end
    if (en[3]) begin
      for (int i = 0; i < NUM_CHAN; i++) begin
        t3[i] <= fx_t'((p2[i] + off2) >> FRAC_BITS);
      end
    end
    if (en[4]) begin
      w4[0] <= prod_t'(KR) * prod_t'(t3[0]);
      w4[1] <= prod_t'(KG) * prod_t'(t3[1]);
      w4[2] <= prod_t'(KB) * prod_t'(t3[2]);
      t4    <= t3;
    end
    if (en[5]) begin
      y5 <= fx_t'(ysum >> FRAC_BITS);
      t5 <= t4;
    end
    if (en[6]) begin
      gy6 <= prod_t'(FX_ONE - cfg_fx.f) * prod_t'(y5);
      for (int i = 0; i < NUM_CHAN; i++) begin
        ft6[i] <= prod_t'(cfg_fx.f) * prod_t'(t5[i]);
      end
    end
    if (en[7]) begin
      for (int i = 0; i < NUM_CHAN; i++) begin
        v7[i] <= fx_t'((gy6 + ft6[i]) >> FRAC_BITS);
      end
    end
    if (en[8]) begin
      o8 <= o_next;
    end
  end

  assign adjusted.valid     = vld[NUM_STAGE];
  assign adjusted.red_out   = o8[0];
  assign adjusted.green_out = o8[1];
  assign adjusted.blue_out  = o8[2];

  // Reset leaves every stage empty.
  assert property (@(posedge clk) rst |=> (vld == '0))
    else $error("pipeline not empty after reset");

  // Input is held off only when every stage holds a pixel.
  assert property (@(posedge clk) disable iff (rst) !en[1] |-> (&vld))
    else $error("input stalled with an empty stage");

  // Contrast and brightness keep each channel within full scale.
  assert property (@(posedge clk) disable iff (rst)
    vld[3] |-> (t3[0] <= FX_ONE) && (t3[1] <= FX_ONE) && (t3[2] <= FX_ONE))
    else $error("scaled channel above full scale");

  // Luminance weights sum to one, so gray stays within full scale.
  assert property (@(posedge clk) disable iff (rst) vld[5] |-> (y5 <= FX_ONE))
    else $error("luminance above full scale");

  // The saturation blend stays within full scale.
  assert property (@(posedge clk) disable iff (rst)
    vld[7] |-> (v7[0] <= FX_ONE) && (v7[1] <= FX_ONE) && (v7[2] <= FX_ONE))
    else $error("blended channel above full scale");

endmodule

FILE: test/tb_rgb_contrast_brightness_saturation.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_rgb_contrast_brightness_saturation: pixel adjuster testbench
// Streams RGB888 pixels through the adjuster under several contrast,
// brightness and saturation settings, with random gaps and stalls on both
// channels and one long receiver stall. Each adjusted pixel is checked
// against a fixed-point computation of the expected color, kept in order.
// ---------------------------------------------------------------------------
module tb_rgb_contrast_brightness_saturation;
  import rcbs_pkg::*;

  localparam cfg_idx_t REG_UNUSED = cfg_idx_t'(3);
  localparam int unsigned PCT_FULL = 100;
  localparam int unsigned RANDOM_PHASES = 12;
  localparam int unsigned PHASE_PIXELS = 140;

  typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
  } pixel_t;

  logic     clk;
  logic     rst;
  logic     cfg_we;
  cfg_idx_t cfg_index;
  pct_t     cfg_data;

  rcbs_in_if  pixel_bus ();
  rcbs_out_if adjusted_bus ();

  rgb_contrast_brightness_saturation u_top (
    .clk      (clk),
    .rst      (rst),
    .pixels   (pixel_bus),
    .adjusted (adjusted_bus),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  pct_t   contrast_pct;
  pct_t   brightness_pct;
  pct_t   saturation_pct;
  pixel_t expected_pixels[$];
  int     errors = 0;
  bit     src_idling;
  bit     sink_idling;
  int     stall_request;
  int     stall_left;
  bit     stall_taken;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

  // Expected color of one pixel under the current settings.
  function automatic pixel_t adjust_pixel(pixel_t px);
    longint unsigned one;
    longint unsigned s;
    longint unsigned b;
    longint unsigned f;
    longint unsigned wr;
    longint unsigned wg;
    longint unsigned wb;
    longint unsigned lum;
    longint unsigned v;
    longint unsigned o;
    longint unsigned chan[3];
    longint unsigned tone[3];
    pixel_t          res;
    one = longint'(1) << FRAC_BITS;
    s = (longint'(contrast_pct) * one) / PCT_FULL;
    b = (longint'(brightness_pct) * one) / PCT_FULL;
    f = (longint'(saturation_pct) * one) / PCT_FULL;
    wr = (37 * one + 50) / 100;
    wg = (24 * one + 50) / 100;
    wb = one - wr - wg;
    chan[0] = px.red;
    chan[1] = px.green;
    chan[2] = px.blue;
    for (int i = 0; i < 3; i++) begin
      tone[i] = (((chan[i] * one + 254) / 255) * s + b * (one - s)) >> FRAC_BITS;
    end
    lum = (wr * tone[0] + wg * tone[1] + wb * tone[2]) >> FRAC_BITS;
    for (int i = 0; i < 3; i++) begin
      v = ((one - f) * lum + f * tone[i]) >> FRAC_BITS;
      o = (255 * v) >> FRAC_BITS;
      chan[i] = (o > 255) ? 255 : o;
    end
    res.red = chan_t'(chan[0]);
    res.green = chan_t'(chan[1]);
    res.blue = chan_t'(chan[2]);
    return res;
  endfunction

  function automatic pct_t limit_pct(pct_t val);
    return (val > PCT_FULL) ? pct_t'(PCT_FULL) : val;
  endfunction

  function automatic chan_t random_chan();
    case ($urandom_range(9))
      0: return chan_t'(0);
      1: return chan_t'(255);
      default: return chan_t'($urandom_range(255));
    endcase
  endfunction

  function automatic pixel_t random_pixel();
    pixel_t px;
    px.red = random_chan();
    px.green = random_chan();
    px.blue = random_chan();
    return px;
  endfunction

  function automatic pct_t random_setting();
    case ($urandom_range(9))
      0, 1: return pct_t'(0);
      2, 3: return pct_t'(PCT_FULL);
      4: return pct_t'($urandom_range(127, 101));
      default: return pct_t'($urandom_range(PCT_FULL));
    endcase
  endfunction

  // Receiver side: random stalls, plus a long hold-off when one is requested.
  always @(posedge clk) begin
    if (rst) begin
      adjusted_bus.ready <= 1'b0;
      stall_left = 0;
      stall_taken = 1'b0;
    end else begin
      if (stall_request > 0 && !stall_taken) begin
        stall_left = stall_request;
        stall_taken = 1'b1;
      end
      if (stall_left > 0) begin
        stall_left = stall_left - 1;
        adjusted_bus.ready <= 1'b0;
      end else begin
        adjusted_bus.ready <= !(sink_idling && $urandom_range(99) < 10);
      end
    end
  end

  always @(posedge clk) begin
    pixel_t got;
    pixel_t want;
    if (!rst && adjusted_bus.valid && adjusted_bus.ready) begin
      got.red = adjusted_bus.red_out;
      got.green = adjusted_bus.green_out;
      got.blue = adjusted_bus.blue_out;
      if (expected_pixels.size() == 0) begin
        $error("unexpected pixel %h", got);
        errors++;
      end else begin
        want = expected_pixels.pop_front();
        if (got.red != want.red) begin
          $error("red_out: expected %0d, got %0d", want.red, got.red);
          errors++;
        end
        if (got.green != want.green) begin
          $error("green_out: expected %0d, got %0d", want.green, got.green);
          errors++;
        end
        if (got.blue != want.blue) begin
          $error("blue_out: expected %0d, got %0d", want.blue, got.blue);
          errors++;
        end
      end
    end
  end

  task automatic send_pixel(pixel_t px);
    while (src_idling && $urandom_range(99) < 10) begin
      pixel_bus.valid <= 1'b0;
      @(posedge clk);
    end
    pixel_bus.valid <= 1'b1;
    pixel_bus.red_in <= px.red;
    pixel_bus.green_in <= px.green;
    pixel_bus.blue_in <= px.blue;
    do @(posedge clk); while (!pixel_bus.ready);
    expected_pixels.push_back(adjust_pixel(px));
  endtask

  task automatic wait_drained();
    pixel_bus.valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, pct_t val);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_CONTRAST: contrast_pct = limit_pct(val);
      REG_BRIGHTNESS: brightness_pct = limit_pct(val);
      REG_SATURATION: saturation_pct = limit_pct(val);
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_levels(pct_t con, pct_t bri, pct_t sat);
    write_reg(REG_CONTRAST, con);
    write_reg(REG_BRIGHTNESS, bri);
    write_reg(REG_SATURATION, sat);
  endtask

  task automatic test_reset_defaults();
    send_pixel('{8'd0, 8'd0, 8'd0});
    send_pixel('{8'd255, 8'd255, 8'd255});
    send_pixel('{8'd255, 8'd0, 8'd0});
    send_pixel('{8'd0, 8'd255, 8'd0});
    send_pixel('{8'd0, 8'd0, 8'd255});
    send_pixel('{8'h55, 8'hAA, 8'h81});
  endtask

  task automatic test_setting_extremes();
    pct_t levels[6][3];
    levels = '{'{7'd0, 7'd0, 7'd0}, '{7'd100, 7'd100, 7'd0},
               '{7'd0, 7'd100, 7'd100}, '{7'd100, 7'd0, 7'd100},
               '{7'd127, 7'd127, 7'd127}, '{7'd101, 7'd64, 7'd115}};
    for (int i = 0; i < 6; i++) begin
      set_levels(levels[i][0], levels[i][1], levels[i][2]);
      send_pixel('{8'd255, 8'd128, 8'd0});
      send_pixel('{8'd1, 8'd254, 8'd127});
    end
  endtask

  task automatic test_unused_register();
    set_levels(7'd60, 7'd30, 7'd80);
    write_reg(REG_UNUSED, 7'd0);
    send_pixel('{8'd200, 8'd40, 8'd90});
    write_reg(REG_UNUSED, 7'd127);
    send_pixel('{8'd17, 8'd230, 8'd160});
  endtask

  task automatic test_random_pixels();
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      src_idling = (phase != 0);
      sink_idling = (phase != 0);
      if (phase == RANDOM_PHASES - 1) begin
        set_levels(pct_t'(PCT_FULL), pct_t'(PCT_FULL), pct_t'(PCT_FULL));
      end else begin
        set_levels(random_setting(), random_setting(), random_setting());
      end
      if ($urandom_range(4) == 0) begin
        write_reg(REG_UNUSED, pct_t'($urandom_range(127)));
      end
      for (int n = 0; n < PHASE_PIXELS; n++) begin
        send_pixel(random_pixel());
      end
    end
  endtask

  task automatic test_receiver_hold_off();
    set_levels(random_setting(), random_setting(), random_setting());
    src_idling = 1'b1;
    sink_idling = 1'b1;
    stall_request = 300;
    for (int n = 0; n < 40; n++) begin
      send_pixel(random_pixel());
    end
  endtask

  initial begin
    int waited;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = REG_CONTRAST;
    cfg_data = '0;
    pixel_bus.valid = 1'b0;
    pixel_bus.red_in = '0;
    pixel_bus.green_in = '0;
    pixel_bus.blue_in = '0;
    contrast_pct = CONTRAST_RESET;
    brightness_pct = BRIGHTNESS_RESET;
    saturation_pct = SATURATION_RESET;
    src_idling = 1'b1;
    sink_idling = 1'b1;
    stall_request = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_defaults();
    test_setting_extremes();
    test_unused_register();
    test_random_pixels();
    test_receiver_hold_off();

    pixel_bus.valid <= 1'b0;
    waited = 0;
    while (expected_pixels.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (16) @(posedge clk);
    if (expected_pixels.size() != 0) begin
      $error("%0d adjusted pixels never arrived", expected_pixels.size());
    end
    if (errors == 0 && expected_pixels.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
